// ===== design/sgb_pkg.sv =====
// Shared types, constants and control records for the separable Gaussian blur.
package sgb_pkg;

  localparam int MAX_COLS_DEF   = 2048;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int PIX_W  = 16;  // pixel field width on the ports
  localparam int DIM_W  = 12;  // frame_cols / frame_rows register width
  localparam int WT_W   = 16;  // Q0.16 tap weight width
  localparam int ROW_W  = 13;  // row counters also count the two drain rows
  localparam int VW     = 33;  // saturated vertical-pass value
  localparam int PROD_W = VW + WT_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int HV_W   = ACC_W - 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] FRAME_COLS_RST    = 12'd1920;
  localparam logic [DIM_W-1:0] FRAME_ROWS_RST    = 12'd1080;
  localparam logic [WT_W-1:0]  EDGE_WEIGHT_RST   = 16'd16164;
  localparam logic [WT_W-1:0]  CENTER_WEIGHT_RST = 16'd39761;
  localparam logic [DIM_W-1:0] MIN_DIM           = 12'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COLS    = 2'd0,
    CFG_FRAME_ROWS    = 2'd1,
    CFG_EDGE_WEIGHT   = 2'd2,
    CFG_CENTER_WEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TAP_FIRST  = 2'd0,
    TAP_MIDDLE = 2'd1,
    TAP_LAST   = 2'd2
  } tap_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_LATCH,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_VDONE,
    ST_HDONE
  } state_t;

  typedef struct packed {
    logic     item_ld;   // capture the accepted input transaction
    logic     cnt_clr;   // start a new frame
    logic     rd_en;     // read both line stores at the current column
    logic     lat;       // line store data valid: write back, load vertical taps
    logic     edge_ld;   // load horizontal taps from the window, right edge
    logic     mul_en;
    tap_sel_t mul_sel;
    logic     acc_ld;
    logic     acc_add;
    logic     vdone;     // vertical value ready: update window
    logic     out_ld;    // horizontal value ready: load output register
    logic     out_final; // this result ends the drain
  } cmd_t;

  typedef struct packed {
    logic restart;  // pixel arrives after the frame's last row
    logic drop;     // flush while pixels are still expected
    logic final_tk; // last drain transaction
    logic row_ge1;
    logic emit_v;   // the vertical value produces a result
    logic out_busy;
  } sts_t;

endpackage

// ===== design/sgb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sgb_ctrl.sv =====
// Sequencing controller: steps each transaction through read, multiply and result phases.
module sgb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sgb_pkg::sts_t       sts,
  output sgb_pkg::cmd_t       cmd
);

  sgb_pkg::state_t state_r, state_nxt;
  logic horiz_r, horiz_nxt;
  logic final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgb_pkg::ST_IDLE;
      horiz_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      horiz_r <= horiz_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    horiz_nxt = horiz_r;
    final_nxt = final_r;
    unique case (state_r)
      sgb_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sgb_pkg::ST_CHECK;
        end
      end
      sgb_pkg::ST_CHECK: begin
        horiz_nxt = 1'b0;
        final_nxt = 1'b0;
        priority if (sts.restart) begin
          state_nxt = sgb_pkg::ST_READ;
        end else if (sts.drop) begin
          state_nxt = sgb_pkg::ST_IDLE;
        end else if (sts.final_tk) begin
          state_nxt = sgb_pkg::ST_MUL0;
          horiz_nxt = 1'b1;
          final_nxt = 1'b1;
        end else begin
          state_nxt = sgb_pkg::ST_READ;
        end
      end
      sgb_pkg::ST_READ:  state_nxt = sgb_pkg::ST_LATCH;
      sgb_pkg::ST_LATCH: begin
        state_nxt = sts.row_ge1 ? sgb_pkg::ST_MUL0 : sgb_pkg::ST_IDLE;
      end
      sgb_pkg::ST_MUL0: state_nxt = sgb_pkg::ST_MUL1;
      sgb_pkg::ST_MUL1: state_nxt = sgb_pkg::ST_MUL2;
      sgb_pkg::ST_MUL2: state_nxt = sgb_pkg::ST_MUL3;
      sgb_pkg::ST_MUL3: begin
        state_nxt = horiz_r ? sgb_pkg::ST_HDONE : sgb_pkg::ST_VDONE;
      end
      sgb_pkg::ST_VDONE: begin
        if (sts.emit_v) begin
          state_nxt = sgb_pkg::ST_MUL0;
          horiz_nxt = 1'b1;
        end else begin
          state_nxt = sgb_pkg::ST_IDLE;
        end
      end
      sgb_pkg::ST_HDONE: begin
        if (!sts.out_busy) begin
          state_nxt = sgb_pkg::ST_IDLE;
          horiz_nxt = 1'b0;
          final_nxt = 1'b0;
        end
      end
      default: state_nxt = sgb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = sgb_pkg::TAP_FIRST;
    in_tready = 1'b0;
    unique case (state_r)
      sgb_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.item_ld = in_tvalid;
      end
      sgb_pkg::ST_CHECK: begin
        cmd.cnt_clr = sts.restart;
        cmd.edge_ld = !sts.restart && !sts.drop && sts.final_tk;
      end
      sgb_pkg::ST_READ:  cmd.rd_en = 1'b1;
      sgb_pkg::ST_LATCH: cmd.lat = 1'b1;
      sgb_pkg::ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sgb_pkg::TAP_FIRST;
      end
      sgb_pkg::ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sgb_pkg::TAP_MIDDLE;
        cmd.acc_ld  = 1'b1;
      end
      sgb_pkg::ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = sgb_pkg::TAP_LAST;
        cmd.acc_add = 1'b1;
      end
      sgb_pkg::ST_MUL3:  cmd.acc_add = 1'b1;
      sgb_pkg::ST_VDONE: cmd.vdone = 1'b1;
      sgb_pkg::ST_HDONE: begin
        cmd.out_ld    = !sts.out_busy;
        cmd.out_final = final_r;
      end
      default: cmd = '0;
    endcase
  end

  // A result is only produced on the horizontal pass.
  a_hdone_horiz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgb_pkg::ST_HDONE) |-> horiz_r)
    else $error("result phase reached outside the horizontal pass");

  a_final_horiz: assert property (@(posedge clk) disable iff (!rst_n)
    final_r |-> horiz_r)
    else $error("drain flag set without horizontal pass");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.item_ld |=> (state_r == sgb_pkg::ST_CHECK))
    else $error("accepted transaction not checked next cycle");

endmodule

// ===== design/sgb_dp.sv =====
// Datapath: line stores, counters, shared multiply-accumulate, window and output register.
module sgb_dp #(
  parameter int MAX_COLS   = sgb_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = sgb_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sgb_pkg::DIM_W-1:0]     frame_cols,
  input  logic [sgb_pkg::DIM_W-1:0]     frame_rows,
  input  logic [sgb_pkg::WT_W-1:0]      edge_weight,
  input  logic [sgb_pkg::WT_W-1:0]      center_weight,
  input  logic                          in_kind,
  input  logic [sgb_pkg::PIX_W-1:0]     in_pixel,
  input  sgb_pkg::cmd_t                 cmd,
  output sgb_pkg::sts_t                 sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sgb_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_line_end,
  output logic                          out_frame_end
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = AW + 1;
  localparam int RW = sgb_pkg::ROW_W;
  localparam int VW = sgb_pkg::VW;
  localparam logic [sgb_pkg::HV_W-1:0] PIX_MAX = sgb_pkg::HV_W'((1 << PIXEL_BITS) - 1);

  logic                      kind_r;
  logic [PIXEL_BITS-1:0]     pix_r;
  logic [CW-1:0]             in_col_r, in_col_nxt;
  logic [RW-1:0]             in_row_r, in_row_nxt;
  logic [CW-1:0]             out_col_r, out_col_nxt;
  logic [RW-1:0]             out_row_r, out_row_nxt;
  logic [VW-1:0]             win_r [3];
  logic [VW-1:0]             op_r [3];
  logic [sgb_pkg::PROD_W-1:0] prod_r;
  logic [sgb_pkg::ACC_W-1:0]  acc_r;
  logic                      out_valid_r;
  logic [sgb_pkg::PIX_W-1:0] out_pixel_r;
  logic                      out_le_r, out_fe_r;

  logic [CW-1:0]             w_eff;
  logic [sgb_pkg::DIM_W-1:0] h_eff;
  logic [RW-1:0]             h_ext;
  logic [AW-1:0]             col_addr;
  logic [PIXEL_BITS-1:0]     a_rd, b_rd, bottom;
  logic                      wr_en;
  logic                      adv_in;
  logic [VW-1:0]             vsat;
  logic [sgb_pkg::HV_W-1:0]  hv;
  logic [sgb_pkg::PIX_W-1:0] hsat;
  logic                      le, fe;
  logic [sgb_pkg::WT_W-1:0]  mul_wt;
  logic [VW-1:0]             mul_op;

  always_comb begin
    if (frame_cols < sgb_pkg::MIN_DIM) begin
      w_eff = CW'(3);
    end else if (32'(frame_cols) > MAX_COLS) begin
      w_eff = CW'(MAX_COLS);
    end else begin
      w_eff = CW'(frame_cols);
    end
    h_eff = (frame_rows < sgb_pkg::MIN_DIM) ? sgb_pkg::MIN_DIM : frame_rows;
  end
  assign h_ext = RW'(h_eff);

  assign sts.restart  = !kind_r && (in_row_r >= h_ext);
  assign sts.drop     = kind_r && (in_row_r < h_ext);
  assign sts.final_tk = in_row_r > h_ext;
  assign sts.row_ge1  = in_row_r != '0;
  assign sts.emit_v   = (in_col_r != '0) || (in_row_r >= RW'(2));
  assign sts.out_busy = out_valid_r;

  assign col_addr = (32'(in_col_r) >= MAX_COLS) ? AW'(MAX_COLS - 1) : in_col_r[AW-1:0];
  assign bottom   = kind_r ? a_rd : pix_r;
  assign wr_en    = cmd.lat && (in_row_r < h_ext);

  // Line store a holds the previous row, b the one before it.
  sgb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_line_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col_addr),
    .wr_data (bottom),
    .rd_en   (cmd.rd_en),
    .rd_addr (col_addr),
    .rd_data (a_rd)
  );

  sgb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_line_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col_addr),
    .wr_data (a_rd),
    .rd_en   (cmd.rd_en),
    .rd_addr (col_addr),
    .rd_data (b_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      kind_r <= in_kind;
      pix_r  <= in_pixel[PIXEL_BITS-1:0];
    end
  end

  // Shared multiplier: one tap per cycle, product registered before the add.
  always_comb begin
    unique case (cmd.mul_sel)
      sgb_pkg::TAP_MIDDLE: begin
        mul_wt = center_weight;
        mul_op = op_r[1];
      end
      sgb_pkg::TAP_LAST: begin
        mul_wt = edge_weight;
        mul_op = op_r[2];
      end
      default: begin
        mul_wt = edge_weight;
        mul_op = op_r[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= sgb_pkg::PROD_W'(mul_wt * mul_op);
    end
    if (cmd.acc_ld) begin
      acc_r <= sgb_pkg::ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + sgb_pkg::ACC_W'(prod_r);
    end
  end

  assign vsat = (acc_r[sgb_pkg::ACC_W-1:VW] != '0) ? '1 : acc_r[VW-1:0];
  assign hv   = acc_r[sgb_pkg::ACC_W-1:32];
  assign hsat = (hv > PIX_MAX) ? sgb_pkg::PIX_W'(PIX_MAX) : sgb_pkg::PIX_W'(hv);

  // Window and tap operands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= '0;
      win_r[1] <= '0;
      win_r[2] <= '0;
    end else if (cmd.vdone) begin
      if (in_col_r == '0) begin
        win_r[0] <= vsat;
        win_r[1] <= vsat;
        win_r[2] <= vsat;
      end else begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= vsat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat) begin
      op_r[0] <= VW'((in_row_r >= RW'(2)) ? b_rd : a_rd);
      op_r[1] <= VW'(a_rd);
      op_r[2] <= VW'(bottom);
    end else if (cmd.edge_ld || (cmd.vdone && in_col_r == '0)) begin
      // Right edge of the previous row: replicate the last vertical value.
      op_r[0] <= win_r[1];
      op_r[1] <= win_r[2];
      op_r[2] <= win_r[2];
    end else if (cmd.vdone) begin
      op_r[0] <= win_r[1];
      op_r[1] <= win_r[2];
      op_r[2] <= vsat;
    end
  end

  // Position counters.
  assign adv_in = cmd.vdone || (cmd.lat && in_row_r == '0);
  assign le = (CW'(out_col_r + CW'(1)) >= w_eff) || (out_col_r >= w_eff);
  assign fe = le && ((RW + 1)'(out_row_r) + (RW + 1)'(1) >= (RW + 1)'(h_eff));

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (adv_in) begin
      if ((CW + 1)'(in_col_r) + (CW + 1)'(1) >= (CW + 1)'(w_eff)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    if (cmd.out_ld) begin
      if (le) begin
        out_col_nxt = '0;
        if (out_row_r != '1) begin
          out_row_nxt = out_row_r + RW'(1);
        end
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    if (cmd.cnt_clr || (cmd.out_ld && cmd.out_final)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_pixel_r <= hsat;
      out_le_r    <= le;
      out_fe_r    <= fe;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_line_end  = out_le_r;
  assign out_frame_end = out_fe_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !out_valid_r)
    else $error("output register overwritten while a result is pending");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(in_col_r) < MAX_COLS)
    else $error("input column beyond line store depth");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_ld))
    else $error("result appeared without a load");

endmodule

// ===== design/separable_gaussian_3x3_stream_top.sv =====
// A pixel transaction is checked, reads and latches both line stores (first row stops there),
// runs the vertical pass and, with a result, the horizontal pass; the result then waits for a
// free output register. The drain transaction goes from the check to the horizontal pass, an
// ignored flush back to idle. A new transaction is taken only once the last one is through; the
// single shared multiplier evaluates the three vertical taps, then the three horizontal taps.
// Reset (synchronous, rst_n low) clears counters, window, controller and output valid;
// registers return to 1920x1080 with weights 16164/39761. Line stores are not cleared.
module separable_gaussian_3x3_stream_top #(
  parameter int MAX_COLS   = sgb_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = sgb_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sgb_pkg::PIX_W-1:0]       in_tdata,   // [15:0] pixel_in
  input  logic                            in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sgb_pkg::PIX_W-1:0]       out_tdata,  // [15:0] pixel_out
  output logic                            out_tlast,  // line_end
  output logic                            out_tuser,  // [0] frame_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgb_pkg::WT_W-1:0]        cfg_data
);

  logic [sgb_pkg::DIM_W-1:0] frame_cols_r, frame_rows_r;
  logic [sgb_pkg::WT_W-1:0]  edge_weight_r, center_weight_r;
  sgb_pkg::cmd_t cmd;
  sgb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r    <= sgb_pkg::FRAME_COLS_RST;
      frame_rows_r    <= sgb_pkg::FRAME_ROWS_RST;
      edge_weight_r   <= sgb_pkg::EDGE_WEIGHT_RST;
      center_weight_r <= sgb_pkg::CENTER_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sgb_pkg::cfg_idx_t'(cfg_index))
        sgb_pkg::CFG_FRAME_COLS:    frame_cols_r    <= cfg_data[sgb_pkg::DIM_W-1:0];
        sgb_pkg::CFG_FRAME_ROWS:    frame_rows_r    <= cfg_data[sgb_pkg::DIM_W-1:0];
        sgb_pkg::CFG_EDGE_WEIGHT:   edge_weight_r   <= cfg_data;
        sgb_pkg::CFG_CENTER_WEIGHT: center_weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgb_dp #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_cols    (frame_cols_r),
    .frame_rows    (frame_rows_r),
    .edge_weight   (edge_weight_r),
    .center_weight (center_weight_r),
    .in_kind       (in_tuser),
    .in_pixel      (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_pixel     (out_tdata),
    .out_line_end  (out_tlast),
    .out_frame_end (out_tuser)
  );

endmodule

// ===== tb/separable_gaussian_3x3_stream_top_tb.sv =====
// Self-checking testbench for the separable 3x3 Gaussian blur stream block.
module separable_gaussian_3x3_stream_top_tb;

  localparam int NCOLS = 2048;
  localparam longint PIXMAX = 65535;
  localparam longint VMAX = (64'd1 << 33) - 1;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [15:0] pixel;
    logic        line_end;
    logic        frame_end;
  } blur_out_t;

  // Scoreboard: a bit-true blur predictor plus the queue of expected pixels.
  class blur_scoreboard;
    logic [11:0] frame_cols, frame_rows;
    logic [15:0] edge_wt, center_wt;
    logic [15:0] row_prev [NCOLS];
    logic [15:0] row_prev2 [NCOLS];
    longint win [3];
    int in_col, in_row, out_col, out_row;
    blur_out_t pending [$];
    int errors;

    function new();
      frame_cols = sgb_pkg::FRAME_COLS_RST;
      frame_rows = sgb_pkg::FRAME_ROWS_RST;
      edge_wt = sgb_pkg::EDGE_WEIGHT_RST;
      center_wt = sgb_pkg::CENTER_WEIGHT_RST;
      foreach (row_prev[i]) begin
        row_prev[i] = '0;
        row_prev2[i] = '0;
      end
      for (int i = 0; i < 3; i++) win[i] = 0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      errors = 0;
    endfunction

    function void set_reg(sgb_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        sgb_pkg::CFG_FRAME_COLS:    frame_cols = val[11:0];
        sgb_pkg::CFG_FRAME_ROWS:    frame_rows = val[11:0];
        sgb_pkg::CFG_EDGE_WEIGHT:   edge_wt = val;
        sgb_pkg::CFG_CENTER_WEIGHT: center_wt = val;
        default: ;
      endcase
    endfunction

    function longint weigh(longint a, longint b, longint c);
      return longint'(edge_wt) * a + longint'(center_wt) * b + longint'(edge_wt) * c;
    endfunction

    function void predict_pixel(longint a, longint b, longint c, int w, int h);
      blur_out_t r;
      longint v;
      v = weigh(a, b, c) >>> 32;
      r.pixel = (v > PIXMAX) ? 16'hFFFF : v[15:0];
      r.line_end = (out_col + 1 >= w);
      r.frame_end = r.line_end && (out_row + 1 >= h);
      pending.push_back(r);
      if (r.line_end) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void note_input(bit flush, logic [15:0] pix);
      int w, h, col;
      longint mid, top, v;
      logic [15:0] bottom;
      w = (frame_cols < 3) ? 3 : int'(frame_cols);
      if (w > NCOLS) w = NCOLS;
      h = (frame_rows < 3) ? 3 : int'(frame_rows);
      if (!flush && in_row >= h) begin
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end
      if (flush && in_row < h) return;
      if (in_row > h) begin
        predict_pixel(win[1], win[2], win[2], w, h);
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        return;
      end
      col = (in_col < NCOLS) ? in_col : NCOLS - 1;
      bottom = flush ? row_prev[col] : pix;
      if (in_row >= 1) begin
        mid = row_prev[col];
        top = (in_row >= 2) ? row_prev2[col] : mid;
        v = weigh(top, mid, bottom);
        if (v > VMAX) v = VMAX;
        if (in_col == 0) begin
          if (in_row >= 2) predict_pixel(win[1], win[2], win[2], w, h);
          win[0] = v; win[1] = v; win[2] = v;
        end else begin
          win[0] = win[1]; win[1] = win[2]; win[2] = v;
          predict_pixel(win[0], win[1], win[2], w, h);
        end
      end
      if (in_row < h) begin
        row_prev2[col] = row_prev[col];
        row_prev[col] = bottom;
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    endfunction

    function void check_result(logic [15:0] pix, logic le, logic fe);
      blur_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result pixel_out=%0d", pix);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.pixel !== pix) begin
        $error("pixel_out expected %0d actual %0d", e.pixel, pix);
        errors++;
      end
      if (e.line_end !== le) begin
        $error("line_end expected %0d actual %0d", e.line_end, le);
        errors++;
      end
      if (e.frame_end !== fe) begin
        $error("frame_end expected %0d actual %0d", e.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  sgb_pkg::cfg_idx_t cfg_index = sgb_pkg::CFG_FRAME_COLS;
  logic [15:0] cfg_data = '0;

  blur_scoreboard blur_sb;
  longint cycles = 0;
  bit hold_sink = 1'b0;
  bit sink_busy_gaps = 1'b1;

  always #2 clk = ~clk;

  separable_gaussian_3x3_stream_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check every accepted transaction, with random back-pressure.
  initial begin
    int gap;
    blur_sb = new();
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        blur_sb.check_result(out_tdata, out_tlast, out_tuser);
      gap = sink_busy_gaps ? $urandom_range(0, 16) : 0;
      if (hold_sink || (out_tready && out_tvalid && gap > 0 && $urandom_range(0, 3) == 0))
        out_tready <= 1'b0;
      else
        out_tready <= (gap < 10) || !sink_busy_gaps;
    end
  end

  // Long receiver stall counted in its own process so the block backs up.
  initial begin
    wait (rst_n);
    repeat (2000) @(posedge clk);
    hold_sink = 1'b1;
    repeat (600) @(posedge clk);
    hold_sink = 1'b0;
  end

  task automatic send_item(bit flush, logic [15:0] pix, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0 && $urandom_range(0, 2) != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= flush;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
    blur_sb.note_input(flush, pix);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic write_reg(sgb_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    blur_sb.set_reg(idx, val);
  endtask

  task automatic settle();
    idle_input();
    while (blur_sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic setup_frame(int cols, int rows, logic [15:0] ew, logic [15:0] cw);
    settle();
    write_reg(sgb_pkg::CFG_FRAME_COLS, cols[15:0]);
    write_reg(sgb_pkg::CFG_FRAME_ROWS, rows[15:0]);
    write_reg(sgb_pkg::CFG_EDGE_WEIGHT, ew);
    write_reg(sgb_pkg::CFG_CENTER_WEIGHT, cw);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One full frame plus its drain; occasional stray flushes inside the frame.
  task automatic send_frame(int cols, int rows, bit gaps, bit extremes);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) begin
        if ($urandom_range(0, 30) == 0) send_item(1'b1, 16'($urandom), gaps);
        send_item(1'b0, extremes ? (((r + c) % 2) ? 16'hFFFF : 16'h0000) : rand_pixel(),
                  gaps);
      end
    for (int k = 0; k < cols + 1; k++) send_item(1'b1, 16'($urandom), gaps);
  endtask

  initial begin
    int cols, rows;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tiny frame at full weights, then zero weights.
    setup_frame(3, 3, 16'hFFFF, 16'hFFFF);
    send_frame(3, 3, 1'b0, 1'b1);
    send_item(1'b1, 16'h1234, 1'b0);  // flush while idle is dropped
    setup_frame(2, 1, 16'h0000, 16'h0000);  // below-minimum sizes clamp to 3x3
    send_frame(3, 3, 1'b0, 1'b0);
    // Pixel during drain starts a new frame.
    setup_frame(3, 3, 16164, 39761);
    send_frame(3, 3, 1'b0, 1'b0);
    setup_frame(4, 3, 16164, 39761);
    for (int i = 0; i < 12; i++) send_item(1'b0, rand_pixel(), 1'b0);
    send_item(1'b1, 16'h0, 1'b0);
    send_item(1'b1, 16'h0, 1'b0);
    send_frame(4, 3, 1'b0, 1'b0);

    // Random frames with random weights and gaps on both sides.
    while (cycles < 2000000 && blur_sb.in_row == 0 && $urandom_range(0, 0) == 0) begin
      for (int f = 0; f < 40; f++) begin
        cols = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8);
        rows = $urandom_range(3, 6);
        sink_busy_gaps = ($urandom_range(0, 4) != 0);
        setup_frame(cols, rows, 16'($urandom), 16'($urandom));
        send_frame(cols, rows, $urandom_range(0, 3) != 0, 1'b0);
      end
      break;
    end

    settle();
    if (blur_sb.errors == 0 && blur_sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
